// ===== hdl/lkv_pkg.sv =====
`default_nettype none

package lkv_pkg;

  // number of cache entries, one cell each
  localparam int ENTRIES = 16;
  // width of a recency rank
  localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  // width of the entries-in-use count, holds ENTRIES itself
  localparam int CNT_W = $clog2(ENTRIES + 1);
  // width of the capacity register
  localparam int CAP_W = 5;
  // common width for comparing count against capacity
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int DATA_W = 32;

  // request codes
  localparam logic REQ_LOOKUP = 1'b0;
  localparam logic REQ_STORE  = 1'b1;

  // capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef struct packed {
    logic              req_type;
    logic signed [DATA_W-1:0] key;
    logic signed [DATA_W-1:0] value;
  } lkv_req_t;

  typedef struct packed {
    logic              hit;
    logic signed [DATA_W-1:0] read_value;
  } lkv_result_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic              cmp;
    logic              upd;
    logic              store;
    logic              hit;
    logic [RANK_W-1:0] hit_rank;
    logic              evict;
    logic [RANK_W-1:0] victim_rank;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] value;
  } lkv_ctrl_t;

  // data handed from one cell to the next
  typedef struct packed {
    logic              hit;
    logic [RANK_W-1:0] rank;
    logic [DATA_W-1:0] value;
    logic              taken;
  } lkv_link_t;

endpackage

`default_nettype wire

// ===== hdl/lkv_cell.sv =====
`default_nettype none

module lkv_cell (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire lkv_pkg::lkv_ctrl_t ctrl,
  input  wire lkv_pkg::lkv_link_t link_in,
  output lkv_pkg::lkv_link_t      link_out
);

  logic [lkv_pkg::DATA_W-1:0] key;
  logic [lkv_pkg::DATA_W-1:0] value;
  logic                       valid;
  logic [lkv_pkg::RANK_W-1:0] rank;
  logic                       match_q;

  logic match;
  logic victim;
  logic free;
  logic ins;

  // key compare, victim and free-slot detection
  always_comb begin
    match  = valid && (key == ctrl.key);
    victim = ctrl.evict && valid && (rank == ctrl.victim_rank);
    free   = !valid || victim;
    ins    = ctrl.upd && ctrl.store && !ctrl.hit && free && !link_in.taken;
  end

  // pass hit data and free-slot claim down the row
  always_comb begin
    link_out.hit   = link_in.hit | match;
    link_out.rank  = match ? rank : link_in.rank;
    link_out.value = match ? value : link_in.value;
    link_out.taken = link_in.taken | free;
  end

  // valid bit, recency rank and hit flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      rank    <= '0;
      match_q <= 1'b0;
    end else begin
      if (ctrl.cmp) begin
        match_q <= match;
      end
      if (ctrl.upd) begin
        if (ctrl.hit) begin
          if (match_q) begin
            rank <= '0;
          end else if (valid && (rank < ctrl.hit_rank)) begin
            rank <= rank + lkv_pkg::RANK_W'(1);
          end
        end else if (ctrl.store) begin
          if (ins) begin
            valid <= 1'b1;
            rank  <= '0;
          end else if (victim) begin
            valid <= 1'b0;
            rank  <= '0;
          end else if (valid) begin
            rank <= rank + lkv_pkg::RANK_W'(1);
          end
        end
      end
    end
  end

  // key and value payload
  always_ff @(posedge clk) begin
    if (ctrl.upd && ctrl.store) begin
      if (ctrl.hit && match_q) begin
        value <= ctrl.value;
      end else if (ins) begin
        key   <= ctrl.key;
        value <= ctrl.value;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lru_key_value_cache.sv =====
// result: a lookup result shows on result with done after the compare state
//   and the recency update state that every request makes through the row of entry cells
// accept: a new request is taken during update of the one before, but not during compare
// busy is high only in the compare cycle; done is a one-cycle strobe, receiver cannot stall
// reset: synchronous, clears all valid bits, ranks and the count; capacity returns to 16
`default_nettype none

module lru_key_value_cache (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire lkv_pkg::lkv_req_t           req,
  output logic                             done,
  output lkv_pkg::lkv_result_t             result,
  input  wire logic                        cfg_we,
  input  wire logic [lkv_pkg::CAP_W-1:0]   cfg_wdata
);

  typedef enum logic [1:0] {
    IDLE,
    CMP,
    UPD
  } state_t;

  state_t                        state;
  lkv_pkg::lkv_req_t             req_q;
  logic                          hit_q;
  logic [lkv_pkg::RANK_W-1:0]    rank_q;
  logic [lkv_pkg::DATA_W-1:0]    value_q;
  logic [lkv_pkg::CNT_W-1:0]     used_count;
  logic [lkv_pkg::CAP_W-1:0]     capacity;

  lkv_pkg::lkv_ctrl_t            ctrl;
  lkv_pkg::lkv_link_t            links [0:lkv_pkg::ENTRIES];

  logic                          store;
  logic                          evict;
  logic [lkv_pkg::CMP_W-1:0]     eff_cap;
  logic [lkv_pkg::RANK_W-1:0]    used_m1;

  assign busy = (state == CMP);

  // effective capacity and eviction decision
  always_comb begin
    if (capacity == '0) begin
      eff_cap = lkv_pkg::CMP_W'(1);
    end else if (lkv_pkg::CMP_W'(capacity) > lkv_pkg::CMP_W'(lkv_pkg::ENTRIES)) begin
      eff_cap = lkv_pkg::CMP_W'(lkv_pkg::ENTRIES);
    end else begin
      eff_cap = lkv_pkg::CMP_W'(capacity);
    end
    store   = (req_q.req_type == lkv_pkg::REQ_STORE);
    evict   = store && !hit_q && (lkv_pkg::CMP_W'(used_count) >= eff_cap);
    used_m1 = lkv_pkg::RANK_W'(used_count - lkv_pkg::CNT_W'(1));
  end

  // broadcast control to the cells
  always_comb begin
    ctrl.cmp         = (state == CMP);
    ctrl.upd         = (state == UPD);
    ctrl.store       = store;
    ctrl.hit         = hit_q;
    ctrl.hit_rank    = rank_q;
    ctrl.evict       = evict;
    ctrl.victim_rank = used_m1;
    ctrl.key         = req_q.key;
    ctrl.value       = req_q.value;
  end

  // head of the row: no hit yet, no slot claimed
  assign links[0] = '0;

  // row of entry cells
  for (genvar i = 0; i < lkv_pkg::ENTRIES; i++) begin : g_cell
    lkv_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .link_in  (links[i]),
      .link_out (links[i+1])
    );
  end

  // sequencer, count, capacity register and result beat
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      done       <= 1'b0;
      used_count <= '0;
      capacity   <= lkv_pkg::CAP_RESET;
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      case (state)
        IDLE, UPD: begin
          if (state == UPD) begin
            if (store) begin
              if (!hit_q && !evict) begin
                used_count <= used_count + lkv_pkg::CNT_W'(1);
              end
            end else begin
              done              <= 1'b1;
              result.hit        <= hit_q;
              result.read_value <= value_q;
            end
          end
          if (start) begin
            req_q <= req;
            state <= CMP;
          end else begin
            state <= IDLE;
          end
        end
        CMP: begin
          hit_q   <= links[lkv_pkg::ENTRIES].hit;
          rank_q  <= links[lkv_pkg::ENTRIES].rank;
          value_q <= links[lkv_pkg::ENTRIES].value;
          state   <= UPD;
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/lkv_checker.sv =====
`default_nettype none

module lkv_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      done,
  input wire lkv_pkg::lkv_result_t      result
);

  // an accepted beat always enters the compare cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // compare lasts exactly one cycle
  a_busy_one: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // busy only rises from an accepted request
  a_busy_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without start");

  // a result beat comes only after the compare state and the update state of a request
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy, 2))
    else $error("result beat without a request");

  // a miss reads as zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.hit |-> result.read_value == '0)
    else $error("miss returned a nonzero value");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);

`default_nettype wire
